// ===== src/sdwcrc_pkg.sv =====
// Shared types, constants and CRC functions for the SD wide-bus CRC16 generator.
package sdwcrc_pkg;

	// CRC16 polynomial x^16+x^12+x^5+1, taken MSB first.
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Number of data lines on the wide bus.
	localparam int NUM_LINES = 4;

	// CRC bytes sent per block, and the width of one packed CRC snapshot.
	localparam int CRC_BEATS = 8;
	localparam int SNAP_W    = 8 * CRC_BEATS;

	typedef logic [15:0] line_crc_t;
	typedef line_crc_t [NUM_LINES-1:0] crc_set_t;
	typedef logic [SNAP_W-1:0] crc_snap_t;

	// Push side of the snapshot queue.
	typedef struct packed {
		logic      push;
		crc_snap_t word;
	} snap_push_t;

	// Fill state of the snapshot queue.
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	// Shift one bit into a line register.
	function automatic line_crc_t crc_bit(input line_crc_t crc, input logic bit_in);
		line_crc_t nxt;
		nxt = {crc[14:0], 1'b0};
		if (crc[15] ^ bit_in) begin
			nxt = nxt ^ CRC_POLY;
		end
		return nxt;
	endfunction

	// Absorb one data byte: high nibble first, nibble bit n feeds line n.
	function automatic crc_set_t crc_byte_update(input crc_set_t crc, input logic [7:0] data);
		crc_set_t nxt;
		for (int n = 0; n < NUM_LINES; n++) begin
			nxt[n] = crc_bit(crc_bit(crc[n], data[4 + n]), data[n]);
		end
		return nxt;
	endfunction

	// Pack the four line registers into eight CRC bytes, first byte in the top bits.
	// Byte k holds register bit 15-2k in its high nibble and bit 14-2k in its low nibble.
	function automatic crc_snap_t crc_interleave(input crc_set_t crc);
		crc_snap_t w;
		for (int k = 0; k < CRC_BEATS; k++) begin
			for (int n = 0; n < NUM_LINES; n++) begin
				w[SNAP_W - 8 - 8 * k + 4 + n] = crc[n][15 - 2 * k];
				w[SNAP_W - 8 - 8 * k + n]     = crc[n][14 - 2 * k];
			end
		end
		return w;
	endfunction

endpackage

// ===== src/sdwcrc_front.sv =====
// Input side: absorbs data beats into the line CRCs and queues a snapshot at block end.
module sdwcrc_front
	import sdwcrc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          block_end,
	input  queue_status_t q_status,
	output snap_push_t    q_push
);

	crc_set_t crc_q;
	crc_set_t crc_next;
	logic     accept;

	// Only a closing beat needs room in the queue.
	assign in_stall = block_end & q_status.full;
	assign accept   = in_valid & ~in_stall;

	// Two bit steps per line for each data beat.
	assign crc_next = crc_byte_update(crc_q, data_byte);

	// Closing beat hands the finished CRCs to the queue.
	assign q_push.push = accept & block_end;
	assign q_push.word = crc_interleave(crc_next);

	// Line registers; cleared after each block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (accept) begin
			crc_q <= block_end ? crc_set_t'('0) : crc_next;
		end
	end

endmodule

// ===== src/sdwcrc_queue.sv =====
// Short queue of finished CRC snapshots between the input and output sides.
module sdwcrc_queue
	import sdwcrc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  snap_push_t    q_push,
	input  logic          pop,
	output crc_snap_t     head,
	output queue_status_t q_status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crc_snap_t         slot_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == CW'(DEPTH));
	assign head           = slot_q[rd_ptr_q];

	assign do_push = q_push.push & ~q_status.full;
	assign do_pop  = pop & ~q_status.empty;

	// Snapshot storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/sdwcrc_back.sv =====
// Output side: sends each queued snapshot as eight CRC beats from a shift register.
module sdwcrc_back
	import sdwcrc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  crc_snap_t     head,
	input  queue_status_t q_status,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    crc_byte,
	output logic          crc_last
);

	localparam logic [2:0] LAST_BEAT = 3'(CRC_BEATS - 1);

	crc_snap_t  shift_q;
	logic [2:0] beat_q;
	logic       busy_q;
	logic       out_take;
	logic       done;

	assign out_valid = busy_q;
	assign crc_byte  = shift_q[SNAP_W-1 -: 8];
	assign crc_last  = (beat_q == LAST_BEAT);

	assign out_take = busy_q & ~out_stall;
	assign done     = out_take & crc_last;

	// Load a new snapshot when idle or as the current one finishes.
	assign pop = ~q_status.empty & (~busy_q | done);

	// Shift register and beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			beat_q  <= '0;
			shift_q <= '0;
		end else if (pop) begin
			busy_q  <= 1'b1;
			beat_q  <= '0;
			shift_q <= head;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (out_take) begin
			beat_q  <= beat_q + 1'b1;
			shift_q <= {shift_q[SNAP_W-9:0], 8'h00};
		end
	end

endmodule

// ===== src/sd_wide_bus_crc16_generator.sv =====
// Top level of the SD wide-bus data CRC16 generator.
//
// Input channel (in_valid / in_stall): one data byte per beat with block_end marking
// the last byte of a block. Each byte updates four CRC16 registers (x^16+x^12+x^5+1,
// zero seed), one per data line, high nibble first. Output channel (out_valid /
// out_stall): after a block's last byte, eight CRC beats follow, each two bit-times
// of the four lines, high nibble first; crc_last marks the eighth. The CRCs reach the
// output via the queue and the shift register. Output runs at one beat per cycle
// while out_stall is low, so each block costs eight output beats; the line CRCs are
// cleared after every block, so the next block's data flows on at once. Finished CRCs
// wait in a queue of QUEUE_DEPTH blocks; only when it is full does a closing data
// beat stall, so sustained input is one byte per cycle as long as blocks average
// eight bytes or more and the output does not stall. A stall on the output holds the
// current beat and fills the queue; ordinary data beats keep flowing meanwhile.
// Reset clears the line CRCs, empties the queue and drops out_valid.
module sd_wide_bus_crc16_generator
	import sdwcrc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       block_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] crc_byte,
	output logic       crc_last
);

	snap_push_t    q_push;
	queue_status_t q_status;
	crc_snap_t     q_head;
	logic          q_pop;

	// CRC update and block end detection.
	sdwcrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.block_end (block_end),
		.q_status  (q_status),
		.q_push    (q_push)
	);

	// Finished CRC snapshots.
	sdwcrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (q_pop),
		.head     (q_head),
		.q_status (q_status)
	);

	// CRC beat serializer.
	sdwcrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_status  (q_status),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.crc_byte  (crc_byte),
		.crc_last  (crc_last)
	);

endmodule

// ===== bench/tb_sd_wide_bus_crc16_generator.sv =====
// Self-checking testbench for the SD wide-bus data CRC16 generator.
`timescale 1ns / 1ps

module tb_sd_wide_bus_crc16_generator
	import sdwcrc_pkg::*;
;

	// One CRC beat as it should appear on the output channel.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} crc_beat_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       block_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] crc_byte;
	logic       crc_last;

	// Running line registers of the predictor and the CRC beats still owed by the block.
	logic [15:0] line_regs [NUM_LINES];
	crc_beat_t   crc_beats_due [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_len = 0;
	logic        holding = 1'b0;
	int unsigned errors = 0;
	int unsigned beats_sent = 0;
	int unsigned blocks_sent = 0;
	int unsigned crc_beats_checked = 0;

	sd_wide_bus_crc16_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.crc_byte  (crc_byte),
		.crc_last  (crc_last)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Print one mismatch line and count it.
	task automatic flag_error(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Shift one serial bit into a line register, MSB first.
	function automatic logic [15:0] shift_line(input logic [15:0] r, input logic b);
		logic [15:0] nxt;
		nxt = {r[14:0], 1'b0};
		if (r[15] ^ b) begin
			nxt = nxt ^ CRC_POLY;
		end
		return nxt;
	endfunction

	// Fold one accepted data beat into the line registers; on a block end queue the
	// eight interleaved CRC beats and clear the registers for the next block.
	task automatic absorb_data_beat(input logic [7:0] value, input logic is_last);
		crc_beat_t beat;
		for (int n = 0; n < NUM_LINES; n++) begin
			line_regs[n] = shift_line(line_regs[n], value[4 + n]);
			line_regs[n] = shift_line(line_regs[n], value[n]);
		end
		if (is_last) begin
			for (int k = 0; k < CRC_BEATS; k++) begin
				for (int n = 0; n < NUM_LINES; n++) begin
					beat.value[4 + n] = line_regs[n][15 - 2 * k];
					beat.value[n]     = line_regs[n][14 - 2 * k];
				end
				beat.last = (k == CRC_BEATS - 1);
				crc_beats_due.push_back(beat);
			end
			for (int n = 0; n < NUM_LINES; n++) begin
				line_regs[n] = '0;
			end
			blocks_sent++;
		end
	endtask

	// Offer one data beat after a random idle gap and wait until the block takes it.
	task automatic send_data_beat(input logic [7:0] value, input logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		block_end <= is_last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		absorb_data_beat(value, is_last);
		beats_sent++;
	endtask

	// Send a whole block of random bytes; the final byte carries the end mark.
	task automatic send_random_block(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_data_beat(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	// Receiver side: random stalls, forced high for the whole of a hold-off.
	always @(posedge clk) begin
		out_stall <= holding || ($urandom_range(99) < rx_idle_pct);
	end

	// Hold-off counter: once a test arms hold_len, keeps the receiver stalled until it runs out.
	always begin
		wait (hold_len != 0);
		holding <= 1'b1;
		repeat (hold_len) @(posedge clk);
		holding <= 1'b0;
		hold_len = 0;
	end

	// Compare every accepted CRC beat against the oldest outstanding prediction.
	always @(posedge clk) begin
		crc_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (crc_beats_due.size() == 0) begin
				flag_error($sformatf("CRC beat %02h (last %0b) with none outstanding",
					crc_byte, crc_last));
			end else begin
				want = crc_beats_due.pop_front();
				if (crc_byte !== want.value) begin
					flag_error($sformatf("crc_byte %02h, predicted %02h", crc_byte, want.value));
				end
				if (crc_last !== want.last) begin
					flag_error($sformatf("crc_last %0b, predicted %0b", crc_last, want.last));
				end
				crc_beats_checked++;
			end
		end
	end

	// Extremes of the byte, single-byte blocks right after reset and back to back,
	// a mixed multi-byte block and a walking-one block.
	task automatic test_directed_blocks();
		send_data_beat(8'h00, 1'b1);
		send_data_beat(8'hFF, 1'b1);
		send_data_beat(8'h80, 1'b1);
		send_data_beat(8'h01, 1'b1);
		send_data_beat(8'hFF, 1'b0);
		send_data_beat(8'h00, 1'b0);
		send_data_beat(8'hA5, 1'b0);
		send_data_beat(8'h5A, 1'b0);
		send_data_beat(8'h3C, 1'b1);
		for (int i = 0; i < 8; i++) begin
			send_data_beat(8'(1 << i), i == 7);
		end
	endtask

	// Random blocks, mostly short, now and then long, until about n beats went in.
	task automatic test_random_blocks(input int unsigned n, input int unsigned tx_pct,
		input int unsigned rx_pct);
		int unsigned target;
		target = beats_sent + n;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (beats_sent < target) begin
			if ($urandom_range(9) == 0) begin
				send_random_block($urandom_range(13, 40));
			end else begin
				send_random_block($urandom_range(1, 12));
			end
		end
	endtask

	// Hold the receiver off long enough that the CRC queue fills and the input stalls.
	task automatic test_output_hold();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_len = 300;
		for (int b = 0; b < 16; b++) begin
			send_random_block($urandom_range(1, 3));
		end
	endtask

	// Stop sending until every owed CRC beat is out, then carry on.
	task automatic test_drain_pause();
		tx_idle_pct = 0;
		rx_idle_pct = 30;
		send_random_block(5);
		send_random_block(1);
		in_valid <= 1'b0;
		while (crc_beats_due.size() != 0) begin
			@(posedge clk);
		end
		send_random_block(4);
	endtask

	// Main sequence: reset, then each test in turn, then drain and report.
	initial begin
		in_valid  <= 1'b0;
		data_byte <= '0;
		block_end <= 1'b0;
		arst_n    <= 1'b0;
		for (int n = 0; n < NUM_LINES; n++) begin
			line_regs[n] = '0;
		end
		tx_idle_pct = 38;
		rx_idle_pct = 60;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_blocks();
		test_random_blocks(70, 38, 60);
		test_random_blocks(70, 60, 38);
		test_random_blocks(70, 0, 0);
		test_output_hold();
		test_drain_pause();

		in_valid <= 1'b0;
		rx_idle_pct = 0;
		while (crc_beats_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d data beats in %0d blocks and checked %0d CRC beats,",
			beats_sent, blocks_sent, crc_beats_checked);
		$display("with idling on both sides, a long output hold-off and a full drain pause.");
		if (errors == 0) begin
			$display("sd_wide_bus_crc16_generator verification clean");
		end else begin
			$display("sd_wide_bus_crc16_generator verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("Timeout with %0d CRC beats outstanding.", crc_beats_due.size());
		$display("sd_wide_bus_crc16_generator verification failed");
		$finish;
	end

endmodule

// ===== sd_wide_bus_crc16_generator.f =====
src/sdwcrc_pkg.sv
src/sdwcrc_front.sv
src/sdwcrc_queue.sv
src/sdwcrc_back.sv
src/sd_wide_bus_crc16_generator.sv
bench/tb_sd_wide_bus_crc16_generator.sv
